// ===== rtl/skat_pkg.sv =====
// ----------------------------------------------------------------------------
// skat_pkg: shared constants for the spi keyed association table
// Sizes of the table and its entries, operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package skat_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int ENTRY_W  = KEY_W + HANDLE_W;

  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/spi_keyed_association_table.sv =====
// ----------------------------------------------------------------------------
// spi_keyed_association_table: insertion-ordered table of spi key / handle
// Add appends, find returns the oldest match, remove takes out the oldest
// match and moves later entries down one place. Entries live in one ram.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  command   in         start, busy            mode_i, spi_key_i, entry_handle_i
//  result    out        done_o (one cycle)     status_o, result_handle_o,
//                                              entry_count_o
//
//  add and no-op words finish in idle: done_o follows the accepting edge.
//  find scans the ram one entry a cycle with a one-deep read pipeline,
//  and stops at the first hit or once every filled place is compared.
//  remove moves each later entry down one place (read, then write through the
//  single ram port pair), then closes. busy is high for find and remove from
//  acceptance until the cycle done_o is shown; reset clears control and the
//  fill count, not the ram, whose contents are never read unwritten below it.
//  the receiver cannot stall: a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_keyed_association_table (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [skat_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [skat_pkg::KEY_W-1:0]       spi_key_i,
  input  wire logic [skat_pkg::HANDLE_W-1:0]    entry_handle_i,
  output logic                                  done_o,
  output logic [skat_pkg::STATUS_W-1:0]         status_o,
  output logic [skat_pkg::HANDLE_W-1:0]         result_handle_o,
  output logic [skat_pkg::COUNT_W-1:0]          entry_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_e;

  state_e                            state_q;
  logic [skat_pkg::MODE_W-1:0]       mode_q;
  logic [skat_pkg::KEY_W-1:0]        key_q;
  logic [skat_pkg::COUNT_W-1:0]      count_q;
  logic [skat_pkg::COUNT_W-1:0]      rd_idx_q;
  logic                              cmp_vld_q;
  logic [skat_pkg::COUNT_W-1:0]      cmp_idx_q;
  logic [skat_pkg::COUNT_W-1:0]      j_q;
  logic                              done_q;
  logic [skat_pkg::STATUS_W-1:0]     status_q;
  logic [skat_pkg::HANDLE_W-1:0]     rh_q;

  logic                              accept;
  logic                              full;
  logic [skat_pkg::COUNT_W-1:0]      j_next;
  logic                              ram_we;
  logic [skat_pkg::ADDR_W-1:0]       ram_waddr;
  logic [skat_pkg::ADDR_W-1:0]       ram_raddr;
  logic [skat_pkg::ENTRY_W-1:0]      ram_wdata;
  logic [skat_pkg::ENTRY_W-1:0]      ram_rdata;
  logic [skat_pkg::KEY_W-1:0]        rd_key;
  logic [skat_pkg::HANDLE_W-1:0]     rd_hnd;
  logic                              key_hit;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign full    = (count_q >= skat_pkg::COUNT_W'(skat_pkg::CAPACITY));
  assign j_next  = j_q + 1'b1;
  assign rd_key  = ram_rdata[skat_pkg::ENTRY_W-1:skat_pkg::HANDLE_W];
  assign rd_hnd  = ram_rdata[skat_pkg::HANDLE_W-1:0];
  // compare unit: the entry read in the previous cycle against the search key
  assign key_hit = cmp_vld_q && (rd_key == key_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_q[skat_pkg::ADDR_W-1:0];
    ram_wdata = {spi_key_i, entry_handle_i};
    ram_raddr = rd_idx_q[skat_pkg::ADDR_W-1:0];
    unique case (state_q)
      S_IDLE: begin
        ram_we = accept && (mode_i == skat_pkg::MODE_ADD) && !full;
      end
      S_SHIFT_RD: begin
        ram_raddr = j_next[skat_pkg::ADDR_W-1:0];
      end
      S_SHIFT_WR: begin
        // entry j+1 read last cycle moves down to j
        ram_we    = 1'b1;
        ram_waddr = j_q[skat_pkg::ADDR_W-1:0];
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  skat_ram #(
    .WIDTH (skat_pkg::ENTRY_W),
    .DEPTH (skat_pkg::CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_vld_q <= 1'b0;
      rd_idx_q  <= '0;
      done_q    <= 1'b0;
      status_q  <= skat_pkg::ST_OK;
      rh_q      <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_q    <= mode_i;
            key_q     <= spi_key_i;
            rd_idx_q  <= '0;
            cmp_vld_q <= 1'b0;
            case (mode_i) inside
              skat_pkg::MODE_ADD: begin
                done_q <= 1'b1;
                if (full) begin
                  status_q <= skat_pkg::ST_FULL;
                  rh_q     <= '0;
                end else begin
                  status_q <= skat_pkg::ST_OK;
                  rh_q     <= entry_handle_i;
                  count_q  <= count_q + 1'b1;
                end
              end
              skat_pkg::MODE_REMOVE, skat_pkg::MODE_FIND: begin
                state_q <= S_SCAN;
              end
              default: begin
                done_q   <= 1'b1;
                status_q <= skat_pkg::ST_OK;
                rh_q     <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (key_hit) begin
            rh_q      <= rd_hnd;
            cmp_vld_q <= 1'b0;
            if (mode_q == skat_pkg::MODE_FIND) begin
              done_q   <= 1'b1;
              status_q <= skat_pkg::ST_OK;
              state_q  <= S_IDLE;
            end else begin
              j_q     <= cmp_idx_q;
              state_q <= S_SHIFT_RD;
            end
          end else if (rd_idx_q < count_q) begin
            cmp_vld_q <= 1'b1;
            cmp_idx_q <= rd_idx_q;
            rd_idx_q  <= rd_idx_q + 1'b1;
          end else begin
            // nothing left to read and no pending compare hit
            cmp_vld_q <= 1'b0;
            done_q    <= 1'b1;
            status_q  <= skat_pkg::ST_MISS;
            rh_q      <= '0;
            state_q   <= S_IDLE;
          end
        end
        S_SHIFT_RD: begin
          if (j_next < count_q) begin
            state_q <= S_SHIFT_WR;
          end else begin
            count_q  <= count_q - 1'b1;
            done_q   <= 1'b1;
            status_q <= skat_pkg::ST_OK;
            state_q  <= S_IDLE;
          end
        end
        S_SHIFT_WR: begin
          j_q     <= j_next;
          state_q <= S_SHIFT_RD;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign result_handle_o = rh_q;
  assign entry_count_o   = count_q;

  // a result is only shown once the sequencer is back at rest
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= skat_pkg::COUNT_W'(skat_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != skat_pkg::ST_OK)) |-> (result_handle_o == '0))
    else $error("nonzero handle on failed operation");

  // fill count moves only together with a result word
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_o)
    else $error("fill count changed without a result");

  a_shift_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_WR) |-> (j_next < count_q))
    else $error("shift write beyond the filled part");

endmodule

`default_nettype wire

// ===== rtl/skat_ram.sv =====
// ----------------------------------------------------------------------------
// skat_ram: generic simple dual port ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module skat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== tb/sv/spi_keyed_association_table_test.sv =====
// ----------------------------------------------------------------------------
// spi_keyed_association_table_test: self-checking bench for the spi key table
// A short directed table covers empty, duplicate, miss and no-op cases, then
// random words built around a small key pool fill, churn and drain the table.
// Each result is compared with a typed expectation or a behavioral copy of the table.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_keyed_association_table_test;

  localparam logic [skat_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
  localparam int POOL_N      = 12;
  localparam int CHUNK_WORDS = 113;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [skat_pkg::STATUS_W-1:0] status;
    logic [skat_pkg::HANDLE_W-1:0] handle;
    logic [skat_pkg::COUNT_W-1:0]  count;
  } table_result_t;

  typedef struct packed {
    logic [skat_pkg::MODE_W-1:0]   mode;
    logic [skat_pkg::KEY_W-1:0]    key;
    logic [skat_pkg::HANDLE_W-1:0] hnd;
    logic                          typed;
    table_result_t                 want;
  } step_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [skat_pkg::MODE_W-1:0]   mode_i = MODE_NOP;
  logic [skat_pkg::KEY_W-1:0]    spi_key_i = '0;
  logic [skat_pkg::HANDLE_W-1:0] entry_handle_i = '0;
  logic                          done_o;
  logic [skat_pkg::STATUS_W-1:0] status_o;
  logic [skat_pkg::HANDLE_W-1:0] result_handle_o;
  logic [skat_pkg::COUNT_W-1:0]  entry_count_o;

  spi_keyed_association_table dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .mode_i,
    .spi_key_i,
    .entry_handle_i,
    .done_o,
    .status_o,
    .result_handle_o,
    .entry_count_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow copy of the table
  logic [skat_pkg::KEY_W-1:0]    shadow_keys    [skat_pkg::CAPACITY];
  logic [skat_pkg::HANDLE_W-1:0] shadow_handles [skat_pkg::CAPACITY];
  int                            shadow_fill;

  table_result_t expected_results [$];
  int            fail_count  = 0;
  int            cycle_count = 0;
  logic [skat_pkg::KEY_W-1:0] key_pool [POOL_N];

  // directed words, starting from an empty table
  step_row_t directed_rows [20] = '{
    '{skat_pkg::MODE_FIND,   32'h0000_0000, 16'h0000, 1'b1,
      '{skat_pkg::ST_MISS, 16'h0000, 7'd0}},
    '{skat_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
      '{skat_pkg::ST_MISS, 16'h0000, 7'd0}},
    '{MODE_NOP,              32'h0000_0000, 16'h0000, 1'b1,
      '{skat_pkg::ST_OK,   16'h0000, 7'd0}},
    '{skat_pkg::MODE_ADD,    32'h0000_0000, 16'h0000, 1'b1,
      '{skat_pkg::ST_OK,   16'h0000, 7'd1}},
    '{skat_pkg::MODE_ADD,    32'hFFFF_FFFF, 16'hFFFF, 1'b1,
      '{skat_pkg::ST_OK,   16'hFFFF, 7'd2}},
    '{skat_pkg::MODE_ADD,    32'h0000_0000, 16'h1234, 1'b1,
      '{skat_pkg::ST_OK,   16'h1234, 7'd3}},
    '{skat_pkg::MODE_ADD,    32'hA5A5_A5A5, 16'h5A5A, 1'b1,
      '{skat_pkg::ST_OK,   16'h5A5A, 7'd4}},
    // duplicate key: oldest entry wins
    '{skat_pkg::MODE_FIND,   32'h0000_0000, 16'hBEEF, 1'b1,
      '{skat_pkg::ST_OK,   16'h0000, 7'd4}},
    '{skat_pkg::MODE_FIND,   32'hFFFF_FFFF, 16'h0000, 1'b1,
      '{skat_pkg::ST_OK,   16'hFFFF, 7'd4}},
    '{skat_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
      '{skat_pkg::ST_OK,   16'h0000, 7'd3}},
    '{skat_pkg::MODE_FIND,   32'h0000_0000, 16'h0000, 1'b0, '0},
    '{skat_pkg::MODE_FIND,   32'h1234_5678, 16'hFFFF, 1'b1,
      '{skat_pkg::ST_MISS, 16'h0000, 7'd3}},
    '{skat_pkg::MODE_ADD,    32'h5A5A_5A5A, 16'hA5A5, 1'b0, '0},
    // remove from the front, later entries shift down
    '{skat_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0},
    '{skat_pkg::MODE_FIND,   32'hA5A5_A5A5, 16'h0000, 1'b0, '0},
    '{MODE_NOP,              32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0},
    '{skat_pkg::MODE_REMOVE, 32'h5A5A_5A5A, 16'h0000, 1'b0, '0},
    '{skat_pkg::MODE_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, '0},
    '{skat_pkg::MODE_REMOVE, 32'hA5A5_A5A5, 16'h0000, 1'b1,
      '{skat_pkg::ST_OK,   16'h5A5A, 7'd0}},
    '{skat_pkg::MODE_REMOVE, 32'hA5A5_A5A5, 16'h0000, 1'b1,
      '{skat_pkg::ST_MISS, 16'h0000, 7'd0}}
  };

  function automatic table_result_t apply_table_op(
    logic [skat_pkg::MODE_W-1:0]   mode,
    logic [skat_pkg::KEY_W-1:0]    key,
    logic [skat_pkg::HANDLE_W-1:0] hnd
  );
    table_result_t res;
    int hit;
    res = '{skat_pkg::ST_OK, '0, '0};
    hit = -1;
    if (mode == skat_pkg::MODE_ADD) begin
      if (shadow_fill >= skat_pkg::CAPACITY) begin
        res.status = skat_pkg::ST_FULL;
      end else begin
        shadow_keys[shadow_fill]    = key;
        shadow_handles[shadow_fill] = hnd;
        shadow_fill++;
        res.handle = hnd;
      end
    end else if (mode == skat_pkg::MODE_REMOVE || mode == skat_pkg::MODE_FIND) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (hit < 0 && shadow_keys[i] == key) hit = i;
      end
      if (hit < 0) begin
        res.status = skat_pkg::ST_MISS;
      end else begin
        res.handle = shadow_handles[hit];
        if (mode == skat_pkg::MODE_REMOVE) begin
          for (int j = hit; j + 1 < shadow_fill; j++) begin
            shadow_keys[j]    = shadow_keys[j + 1];
            shadow_handles[j] = shadow_handles[j + 1];
          end
          shadow_fill--;
        end
      end
    end
    res.count = skat_pkg::COUNT_W'(shadow_fill);
    return res;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic issue_word(input logic [skat_pkg::MODE_W-1:0]   mode,
                            input logic [skat_pkg::KEY_W-1:0]    key,
                            input logic [skat_pkg::HANDLE_W-1:0] hnd,
                            input int                            idle_pct,
                            input logic                          typed,
                            input table_result_t                 want);
    table_result_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start          <= 1'b1;
    mode_i         <= mode;
    spi_key_i      <= key;
    entry_handle_i <= hnd;
    do @(posedge clk_i); while (busy);
    predicted = apply_table_op(mode, key, hnd);
    expected_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    table_result_t exp_word;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: status %0d handle %0h count %0d",
               status_o, result_handle_o, entry_count_o);
        fail_count++;
      end else begin
        exp_word = expected_results.pop_front();
        if (status_o !== exp_word.status) begin
          $error("status: expected %0d, got %0d", exp_word.status, status_o);
          fail_count++;
        end
        if (result_handle_o !== exp_word.handle) begin
          $error("result_handle: expected %0h, got %0h", exp_word.handle, result_handle_o);
          fail_count++;
        end
        if (entry_count_o !== exp_word.count) begin
          $error("entry_count: expected %0d, got %0d", exp_word.count, entry_count_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int idle_plan [4];
    int add_plan  [4];
    logic [skat_pkg::MODE_W-1:0] mode;
    int roll;

    idle_plan = '{0, 72, 6, 72};
    add_plan  = '{80, 55, 25, 65};
    shadow_fill = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[r]) begin
      issue_word(directed_rows[r].mode, directed_rows[r].key, directed_rows[r].hnd,
                 0, directed_rows[r].typed, directed_rows[r].want);
    end
    wait_for_results();

    // fill, churn near full, drain, refill under different gap patterns
    for (int c = 0; c < 4; c++) begin
      for (int n = 0; n < CHUNK_WORDS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_plan[c]) begin
          mode = skat_pkg::MODE_ADD;
        end else begin
          roll = $urandom_range(0, 9);
          mode = (roll == 0) ? MODE_NOP :
                 (roll < 5)  ? skat_pkg::MODE_REMOVE : skat_pkg::MODE_FIND;
        end
        issue_word(mode,
                   ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                               : skat_pkg::KEY_W'($urandom),
                   skat_pkg::HANDLE_W'($urandom_range(0, 65535)), idle_plan[c], 1'b0, '0);
      end
      // hold the sender off until the table has answered everything
      wait_for_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== spi_keyed_association_table.f =====
rtl/skat_pkg.sv
rtl/skat_ram.sv
rtl/spi_keyed_association_table.sv
tb/sv/spi_keyed_association_table_test.sv
